// ===== hdl/gossip_view_cache_merge_macros.svh =====
// ----------------------------------------------------------------------------
// Gossip view cache assertion macros
// Concurrent assertion helpers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef GOSSIP_VIEW_CACHE_MERGE_MACROS_SVH
`define GOSSIP_VIEW_CACHE_MERGE_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define GVCM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gvcm assertion failed");
// condition that must never be true outside reset
`define GVCM_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gvcm forbidden condition seen");
`else
`define GVCM_ASSERT(name, clk, rst_n, prop)
`define GVCM_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== hdl/gvcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Gossip view cache package
// Sizes, codes and the probe packet that walks the cell chain.
// ----------------------------------------------------------------------------
package gvcm_pkg;

  localparam int CACHE_DEPTH = 16;
  localparam int ID_BITS     = 16;

  // field widths of the transaction payloads
  localparam int AGENT_W = 16;
  localparam int TIME_W  = 32;
  localparam int RIDX_W  = 4;
  localparam int ECNT_W  = 5;
  localparam int CSIZE_W = 5;

  localparam int STORE_ID_W = (ID_BITS < AGENT_W) ? ID_BITS : AGENT_W;
  localparam int IDX_W      = $clog2(CACHE_DEPTH);
  localparam int CNT_W      = $clog2(CACHE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_TTL        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_SIZE = 1'd1;
  localparam logic [TIME_W-1:0]    TTL_RESET        = 32'd100;
  localparam logic [CSIZE_W-1:0]   CACHE_SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_EXPIRE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  // probe packet, updated by every cell it passes
  typedef struct packed {
    func_e                  func;
    logic [STORE_ID_W-1:0]  agent;
    logic [TIME_W-1:0]      ts;
    logic                   exp_en;
    logic [TIME_W-1:0]      exp_limit;
    logic                   rd_ok;
    logic [IDX_W-1:0]       rd_idx;
    logic                   match;
    logic [IDX_W-1:0]       match_idx;
    logic [TIME_W-1:0]      match_time;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   old_have;
    logic [IDX_W-1:0]       old_idx;
    logic [TIME_W-1:0]      old_time;
    logic [CNT_W-1:0]       cnt;
    logic                   rd_valid;
    logic [STORE_ID_W-1:0]  rd_agent;
    logic [TIME_W-1:0]      rd_time;
  } pkt_t;

  // write-back broadcast to the cells at the end of an insert
  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       idx;
    logic [STORE_ID_W-1:0]  agent;
    logic [TIME_W-1:0]      ts;
  } wr_t;

endpackage

// ===== hdl/gvcm_in_if.sv =====
// ----------------------------------------------------------------------------
// Gossip view cache request channel
// Valid/ready channel that carries one cache operation.
// ----------------------------------------------------------------------------
interface gvcm_in_if
  import gvcm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [AGENT_W-1:0] agent_id;
  logic [TIME_W-1:0]  timestamp;
  logic [TIME_W-1:0]  current_time;
  logic [RIDX_W-1:0]  read_index;

  modport source (
    output valid, func, agent_id, timestamp, current_time, read_index,
    input  ready
  );
  modport sink (
    input  valid, func, agent_id, timestamp, current_time, read_index,
    output ready
  );
endinterface

// ===== hdl/gvcm_out_if.sv =====
// ----------------------------------------------------------------------------
// Gossip view cache response channel
// Valid/ready channel that carries one operation result.
// ----------------------------------------------------------------------------
interface gvcm_out_if
  import gvcm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [AGENT_W-1:0] out_agent_id;
  logic [TIME_W-1:0]  out_timestamp;
  logic               out_valid;
  logic [ECNT_W-1:0]  entry_count;
  logic               accepted;

  modport source (
    output valid, out_agent_id, out_timestamp, out_valid, entry_count, accepted,
    input  ready
  );
  modport sink (
    input  valid, out_agent_id, out_timestamp, out_valid, entry_count, accepted,
    output ready
  );
endinterface

// ===== hdl/gvcm_cell.sv =====
// ----------------------------------------------------------------------------
// Gossip view cache cell
// One cache slot; folds its entry into the passing probe packet.
// ----------------------------------------------------------------------------
module gvcm_cell
  import gvcm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  logic             in_v_i,
  input  pkt_t             pkt_i,
  input  logic             hold_i,
  input  logic             clear_i,
  input  wr_t              wr_i,
  output logic             out_v_o,
  output pkt_t             pkt_o
);

  logic                  valid_q, valid_d;
  logic [STORE_ID_W-1:0] agent_q;
  logic [TIME_W-1:0]     time_q;
  logic                  out_v_q;
  pkt_t                  pkt_q, pkt_d;
  logic                  hit, drop, wr_hit;

  assign hit    = valid_q && (agent_q == pkt_i.agent);
  assign drop   = (pkt_i.func == FUNC_EXPIRE) && pkt_i.exp_en && valid_q &&
                  (time_q < pkt_i.exp_limit);
  assign wr_hit = wr_i.en && (wr_i.idx == cell_idx_i);

  always_comb begin
    pkt_d = pkt_i;
    if (!pkt_i.match && hit) begin
      pkt_d.match      = 1'b1;
      pkt_d.match_idx  = cell_idx_i;
      pkt_d.match_time = time_q;
    end
    // first free slot in ascending order
    if (!pkt_i.free_found && !valid_q) begin
      pkt_d.free_found = 1'b1;
      pkt_d.free_idx   = cell_idx_i;
    end
    // strictly older only, so the lowest slot wins a tie
    if (valid_q && (!pkt_i.old_have || (time_q < pkt_i.old_time))) begin
      pkt_d.old_have = 1'b1;
      pkt_d.old_idx  = cell_idx_i;
      pkt_d.old_time = time_q;
    end
    if (pkt_i.rd_ok && (pkt_i.rd_idx == cell_idx_i) && valid_q) begin
      pkt_d.rd_valid = 1'b1;
      pkt_d.rd_agent = agent_q;
      pkt_d.rd_time  = time_q;
    end
    if (valid_q && !drop) begin
      pkt_d.cnt = pkt_i.cnt + CNT_W'(1);
    end
  end

  always_comb begin
    valid_d = valid_q;
    priority if (clear_i) begin
      valid_d = 1'b0;
    end else if (wr_hit) begin
      valid_d = 1'b1;
    end else if (in_v_i && drop) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      out_v_q <= in_v_i || (out_v_q && hold_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      agent_q <= wr_i.agent;
      time_q  <= wr_i.ts;
    end
    if (in_v_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign out_v_o = out_v_q;
  assign pkt_o   = pkt_q;

endmodule

// ===== hdl/gossip_view_cache_merge.sv =====
// ----------------------------------------------------------------------------
// Gossip view cache merge
// Bounded news cache of (agent id, timestamp) entries built as a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per transaction: insert, expire, read or clear.
//   out_o returns exactly one result transaction per operation, in order.
//   cfg_we_i/cfg_idx_i/cfg_data_i write ttl and cache_size; write them only
//   while no operation is in flight.
// Path: the first cell folds the probe packet in on the accepting edge, the
//   packet then advances one cell per cycle through the other cells, and a
//   commit cycle writes the chosen slot back and loads the result into the
//   output register.
// Pacing: one operation is in the chain at a time, so a new one is accepted
//   only after the commit, and ready returns the cycle after the commit.
// Reset: every slot invalid, ttl = 100, cache_size = 16. Slot contents are
//   undefined until written but are never returned unless valid.
// Stall: a result waits in the output register while out_o.ready is low; the
//   next operation is still accepted and walks the chain, then holds in the
//   last cell until the output register frees up.
// ----------------------------------------------------------------------------
`include "gossip_view_cache_merge_macros.svh"

module gossip_view_cache_merge
  import gvcm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gvcm_in_if.sink               in_i,
  gvcm_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LAST = CACHE_DEPTH - 1;

  // configuration registers
  logic [TIME_W-1:0]  ttl_q;
  logic [CSIZE_W-1:0] cache_size_q;
  logic [CNT_W-1:0]   lim;

  // chain
  pkt_t                   chain_pkt [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] chain_v;
  pkt_t                   pkt_init;
  pkt_t                   fin;
  logic                   in_fire, busy_q, done, commit;

  // write-back and result
  wr_t                wr;
  logic               clear;
  logic               acc;
  logic [CNT_W-1:0]   cnt_n;
  logic               out_valid_q;
  logic [AGENT_W-1:0] out_agent_q;
  logic [TIME_W-1:0]  out_time_q;
  logic               out_rd_valid_q;
  logic [ECNT_W-1:0]  out_count_q;
  logic               out_acc_q;
  logic               rd_hit;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q        <= TTL_RESET;
      cache_size_q <= CACHE_SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TTL:        ttl_q        <= cfg_data_i[TIME_W-1:0];
        REG_CACHE_SIZE: cache_size_q <= cfg_data_i[CSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the size limit into 1..CACHE_DEPTH
  always_comb begin
    priority if (cache_size_q == '0) begin
      lim = CNT_W'(1);
    end else if (32'(cache_size_q) > 32'(CACHE_DEPTH)) begin
      lim = CNT_W'(CACHE_DEPTH);
    end else begin
      lim = CNT_W'(cache_size_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Launch: build the probe packet from the accepted transaction
  // ---------------------------------------------------------------------------
  assign in_i.ready = !busy_q;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    pkt_init           = '0;
    pkt_init.func      = func_e'(in_i.func);
    pkt_init.agent     = in_i.agent_id[STORE_ID_W-1:0];
    pkt_init.ts        = in_i.timestamp;
    // nothing expires while current_time is below ttl
    pkt_init.exp_en    = (in_i.current_time >= ttl_q);
    pkt_init.exp_limit = in_i.current_time - ttl_q;
    pkt_init.rd_ok     = (32'(in_i.read_index) < 32'(CACHE_DEPTH));
    pkt_init.rd_idx    = IDX_W'(in_i.read_index);
  end

  // ---------------------------------------------------------------------------
  // Cell chain: the packet advances one cell per cycle, the last cell holds it
  // until commit
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    logic in_v;
    pkt_t in_pkt;
    logic hold;

    if (i == 0) begin : g_head
      assign in_v   = in_fire;
      assign in_pkt = pkt_init;
    end else begin : g_body
      assign in_v   = chain_v[i-1];
      assign in_pkt = chain_pkt[i-1];
    end

    assign hold = (i == LAST) ? !commit : 1'b0;

    gvcm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .in_v_i     (in_v),
      .pkt_i      (in_pkt),
      .hold_i     (hold),
      .clear_i    (clear),
      .wr_i       (wr),
      .out_v_o    (chain_v[i]),
      .pkt_o      (chain_pkt[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Commit: decide the insert write-back, clear, and the result
  // ---------------------------------------------------------------------------
  assign fin    = chain_pkt[LAST];
  assign done   = chain_v[LAST];
  assign commit = done && (!out_valid_q || out_o.ready);

  always_comb begin
    wr       = '0;
    wr.agent = fin.agent;
    wr.ts    = fin.ts;
    clear    = 1'b0;
    acc      = 1'b0;
    cnt_n    = fin.cnt;
    if (commit) begin
      unique case (fin.func)
        FUNC_INSERT: begin
          priority if (fin.match) begin
            // known agent: keep the newer timestamp
            if (fin.ts > fin.match_time) begin
              wr.en  = 1'b1;
              wr.idx = fin.match_idx;
              acc    = 1'b1;
            end
          end else if (fin.cnt < lim) begin
            wr.en  = 1'b1;
            wr.idx = fin.free_idx;
            acc    = 1'b1;
            cnt_n  = fin.cnt + CNT_W'(1);
          end else if (fin.old_have && (fin.ts > fin.old_time)) begin
            // full: replace the oldest entry only if strictly fresher
            wr.en  = 1'b1;
            wr.idx = fin.old_idx;
            acc    = 1'b1;
          end
        end
        FUNC_EXPIRE: ;
        FUNC_READ:   ;
        FUNC_CLEAR: begin
          clear = 1'b1;
          cnt_n = '0;
        end
      endcase
    end
  end

  assign rd_hit = (fin.func == FUNC_READ) && fin.rd_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      priority if (in_fire) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      priority if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_agent_q    <= rd_hit ? AGENT_W'(fin.rd_agent) : '0;
      out_time_q     <= rd_hit ? fin.rd_time : '0;
      out_rd_valid_q <= rd_hit;
      out_count_q    <= ECNT_W'(cnt_n);
      out_acc_q      <= acc;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_agent_id  = out_agent_q;
  assign out_o.out_timestamp = out_time_q;
  assign out_o.out_valid     = out_rd_valid_q;
  assign out_o.entry_count   = out_count_q;
  assign out_o.accepted      = out_acc_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // at most one probe packet walks the chain
  `GVCM_ASSERT(a_single_probe, clk_i, rst_ni, $onehot0(chain_v))
  // a new transaction enters only an empty chain
  `GVCM_ASSERT(a_launch_empty, clk_i, rst_ni, in_fire |-> (chain_v == '0))
  // an insert below the size limit always finds a free slot
  `GVCM_ASSERT(a_free_slot, clk_i, rst_ni,
    (done && (fin.func == FUNC_INSERT) && !fin.match && (fin.cnt < lim)) |-> fin.free_found)
  // the valid count never exceeds the slot count
  `GVCM_ASSERT_NEVER(a_count_range, clk_i, rst_ni, done && (32'(fin.cnt) > CACHE_DEPTH))

endmodule
